// ===== hdl/ppb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppb_pkg
// Types and constants shared by the particle project/bounce block.
// ----------------------------------------------------------------------------
package ppb_pkg;

  localparam int DIV_W = 26;

  localparam logic [15:0] DEPTH_BIAS = 16'd9000;
  localparam logic [15:0] COL_BIAS   = 16'd20;
  localparam logic [15:0] ROW_BIAS   = 16'd24;
  localparam logic [15:0] COL_LIMIT  = 16'd39;
  localparam logic [15:0] ROW_LIMIT  = 16'd47;
  localparam logic [DIV_W-1:0] SHADOW_NUM = DIV_W'(32'h80000);

  localparam logic [2:0] REG_ROT_SINE   = 3'd0;
  localparam logic [2:0] REG_ROT_COSINE = 3'd1;
  localparam logic [2:0] REG_GRAVITY    = 3'd2;
  localparam logic [2:0] REG_DAMPING    = 3'd3;
  localparam logic [2:0] REG_FLOOR      = 3'd4;

  localparam logic KIND_LOAD = 1'b0;

  typedef struct packed {
    logic        kind;
    logic [7:0]  dot_index;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [15:0] speed_y;
  } in_item_t;

  typedef struct packed {
    logic [5:0] screen_col;
    logic [5:0] shadow_row;
    logic [5:0] ball_row;
    logic       shadow_drawn;
    logic       ball_drawn;
  } out_item_t;

  typedef struct packed {
    logic [15:0] rot_sine;
    logic [15:0] rot_cosine;
    logic [15:0] gravity_step;
    logic [15:0] bounce_damping;
    logic [15:0] floor_level;
  } cfg_t;

  typedef enum logic [1:0] {
    DSEL_COL,
    DSEL_SHD,
    DSEL_BALL
  } div_sel_e;

  typedef struct packed {
    logic     capture;
    logic     clr_wr;
    logic     ld_wr;
    logic     prod;
    logic     geom;
    logic     div_go;
    div_sel_e div_sel;
    logic     take_col;
    logic     take_shd;
    logic     upd_add;
    logic     upd_mul;
    logic     upd_wr;
    logic     take_ball;
    logic     res_load;
    logic     res_zero;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic in_range;
    logic clr_last;
    logic div_done;
    logic col_ok;
    logic shd_ok;
    logic out_free;
  } status_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_FETCH,
    ST_GEOM,
    ST_COL_GO,
    ST_COL_WAIT,
    ST_COL_CHK,
    ST_SHD_GO,
    ST_SHD_WAIT,
    ST_SHD_CHK,
    ST_UPD_ADD,
    ST_UPD_MUL,
    ST_UPD_WR,
    ST_BALL_GO,
    ST_BALL_WAIT,
    ST_RESULT,
    ST_RES_ZERO
  } state_e;

endpackage
`default_nettype wire

// ===== hdl/ppb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/ppb_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppb_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating towards zero.
// ----------------------------------------------------------------------------
module ppb_div
  import ppb_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [DIV_W-1:0] dividend_i,
  input  wire logic [15:0]             divisor_i,
  output logic                         done_o,
  output logic signed [DIV_W-1:0]      quotient_o
);

  localparam int CW = $clog2(DIV_W);

  logic            busy_q, done_q, neg_q;
  logic [CW-1:0]   cnt_q;
  logic [15:0]     rem_q, dvs_q;
  logic [DIV_W-1:0] quo_q;
  logic [16:0]     trial;
  logic            fit;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fit   = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIV_W-1];
      quo_q <= dividend_i[DIV_W-1] ? DIV_W'(-dividend_i) : DIV_W'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fit ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
      quo_q <= {quo_q[DIV_W-2:0], fit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule
`default_nettype wire

// ===== hdl/ppb_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppb_dp
// Datapath: particle RAM, rotation products, depth, divider operands,
// bounce update and result register.
// ----------------------------------------------------------------------------
module ppb_dp
  import ppb_pkg::*;
#(
  parameter int DOT_COUNT = 256
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  in_data_i,
  input  wire cfg_t      cfg_i,
  input  wire cmd_t      cmd_i,
  output status_t        status_o,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  output out_item_t      out_data_o
);

  localparam int AW = (DOT_COUNT > 1) ? $clog2(DOT_COUNT) : 1;

  in_item_t           in_q;
  logic [AW-1:0]      clr_cnt_q;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, idx_addr;
  logic [63:0]        ram_wdata, ram_rdata;

  logic signed [15:0] x_q, y_q, z_q, spd_q;
  logic signed [31:0] p_xc_q, p_zs_q, p_zc_q, p_xs_q;
  logic signed [31:0] t_sum, u_sum;
  logic signed [23:0] u24;
  logic [15:0]        depth_raw;
  logic [15:0]        depth_q;
  logic signed [24:0] u_q;

  logic signed [DIV_W-1:0] div_a, quo, q_c, q_b;
  logic                    div_done;

  logic [15:0]        col16, shd16, ball16;
  logic [5:0]         col_q, shd_q, ball_q;
  logic               col_ok_q, shd_ok_q, ball_ok_q;

  logic signed [15:0] spd1_q, ny1_q, prod_q, spd_f, ny_f, ny_q;
  logic               bounce_q;
  logic [15:0]        prod_full;

  logic               out_valid_q;
  out_item_t          out_q;

  assign idx_addr = AW'(in_q.dot_index);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  always_comb begin
    ram_we    = cmd_i.clr_wr | cmd_i.ld_wr | cmd_i.upd_wr;
    ram_waddr = idx_addr;
    ram_wdata = {x_q, ny_f, z_q, spd_f};
    if (cmd_i.clr_wr) begin
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (cmd_i.ld_wr) begin
      ram_wdata = {in_q.pos_x, in_q.pos_y, in_q.pos_z, in_q.speed_y};
    end
  end

  ppb_ram #(
    .WIDTH (64),
    .DEPTH (DOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_addr),
    .rdata_o (ram_rdata)
  );

  // rotation products
  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      x_q    <= ram_rdata[63:48];
      y_q    <= ram_rdata[47:32];
      z_q    <= ram_rdata[31:16];
      spd_q  <= ram_rdata[15:0];
      p_xc_q <= $signed(ram_rdata[63:48]) * $signed(cfg_i.rot_cosine);
      p_zs_q <= $signed(ram_rdata[31:16]) * $signed(cfg_i.rot_sine);
      p_zc_q <= $signed(ram_rdata[31:16]) * $signed(cfg_i.rot_cosine);
      p_xs_q <= $signed(ram_rdata[63:48]) * $signed(cfg_i.rot_sine);
    end
  end

  assign t_sum     = p_zc_q - p_xs_q;
  assign u_sum     = p_xc_q + p_zs_q;
  assign u24       = u_sum[31:8];
  assign depth_raw = t_sum[31:16] + DEPTH_BIAS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.geom) begin
      depth_q <= (depth_raw == 16'd0) ? 16'd1 : depth_raw;
      u_q     <= {u24[23], u24} + {{4{u24[23]}}, u24[23:3]};
    end
  end

  always_comb begin
    case (cmd_i.div_sel)
      DSEL_COL:  div_a = DIV_W'(u_q);
      DSEL_SHD:  div_a = SHADOW_NUM;
      DSEL_BALL: div_a = {{(DIV_W-22){ny_q[15]}}, ny_q, 6'b0};
      default:   div_a = '0;
    endcase
  end

  ppb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (div_a),
    .divisor_i  (depth_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // truncating division of the quotient by 8 and by 4
  assign q_c    = quo[DIV_W-1] ? (quo + DIV_W'(7)) >>> 3 : quo >>> 3;
  assign q_b    = quo[DIV_W-1] ? (quo + DIV_W'(3)) >>> 2 : quo >>> 2;
  assign col16  = q_c[15:0] + COL_BIAS;
  assign shd16  = q_b[15:0] + ROW_BIAS;
  assign ball16 = q_b[15:0] + ROW_BIAS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_col) begin
      col_q    <= col16[5:0];
      col_ok_q <= col16 <= COL_LIMIT;
    end
    if (cmd_i.take_shd) begin
      shd_q    <= shd16[5:0];
      shd_ok_q <= shd16 <= ROW_LIMIT;
    end
    if (cmd_i.take_ball) begin
      ball_q    <= ball16[5:0];
      ball_ok_q <= ball16 <= ROW_LIMIT;
    end
  end

  // gravity and floor bounce
  assign prod_full = (16'd0 - spd1_q) * cfg_i.bounce_damping;
  assign spd_f     = bounce_q ? (prod_q >>> 4) : spd1_q;
  assign ny_f      = bounce_q ? ny1_q + (prod_q >>> 4) : ny1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_add) begin
      spd1_q   <= spd_q + $signed(cfg_i.gravity_step);
      ny1_q    <= y_q + spd_q + $signed(cfg_i.gravity_step);
    end
    if (cmd_i.upd_mul) begin
      bounce_q <= ny1_q >= $signed(cfg_i.floor_level);
      prod_q   <= prod_full;
    end
    if (cmd_i.upd_wr) begin
      ny_q     <= ny_f;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load || cmd_i.res_zero) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_zero) begin
      out_q <= '0;
    end else if (cmd_i.res_load) begin
      out_q.screen_col   <= col_q;
      out_q.shadow_row   <= shd_q;
      out_q.ball_row     <= ball_ok_q ? ball_q : 6'd0;
      out_q.shadow_drawn <= 1'b1;
      out_q.ball_drawn   <= ball_ok_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    status_o.kind     = in_q.kind;
    status_o.in_range = 32'(in_q.dot_index) < DOT_COUNT;
    status_o.clr_last = clr_cnt_q == AW'(DOT_COUNT - 1);
    status_o.div_done = div_done;
    status_o.col_ok   = col_ok_q;
    status_o.shd_ok   = shd_ok_q;
    status_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule
`default_nettype wire

// ===== hdl/ppb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppb_ctrl
// Controller: clearing pass, item decode and step sequencing.
// ----------------------------------------------------------------------------
module ppb_ctrl
  import ppb_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.div_sel = DSEL_COL;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (status_i.kind == KIND_LOAD) begin
          cmd_o.ld_wr = status_i.in_range;
          state_d     = ST_IDLE;
        end else if (!status_i.in_range) begin
          state_d = ST_RES_ZERO;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.prod = 1'b1;
        state_d    = ST_GEOM;
      end
      ST_GEOM: begin
        cmd_o.geom = 1'b1;
        state_d    = ST_COL_GO;
      end
      ST_COL_GO: begin
        cmd_o.div_go = 1'b1;
        state_d      = ST_COL_WAIT;
      end
      ST_COL_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.take_col = 1'b1;
          state_d        = ST_COL_CHK;
        end
      end
      ST_COL_CHK: begin
        state_d = status_i.col_ok ? ST_SHD_GO : ST_RES_ZERO;
      end
      ST_SHD_GO: begin
        cmd_o.div_sel = DSEL_SHD;
        cmd_o.div_go  = 1'b1;
        state_d       = ST_SHD_WAIT;
      end
      ST_SHD_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.take_shd = 1'b1;
          state_d        = ST_SHD_CHK;
        end
      end
      ST_SHD_CHK: begin
        state_d = status_i.shd_ok ? ST_UPD_ADD : ST_RES_ZERO;
      end
      ST_UPD_ADD: begin
        cmd_o.upd_add = 1'b1;
        state_d       = ST_UPD_MUL;
      end
      ST_UPD_MUL: begin
        cmd_o.upd_mul = 1'b1;
        state_d       = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd_o.upd_wr = 1'b1;
        state_d      = ST_BALL_GO;
      end
      ST_BALL_GO: begin
        cmd_o.div_sel = DSEL_BALL;
        cmd_o.div_go  = 1'b1;
        state_d       = ST_BALL_WAIT;
      end
      ST_BALL_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.take_ball = 1'b1;
          state_d         = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_RES_ZERO: begin
        if (status_i.out_free) begin
          cmd_o.res_zero = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/particle_project_bounce.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// particle_project_bounce
// Particle table with rotation, perspective projection and floor bounce.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_item_t  (load or step)
//   out      output     out_valid/out_ready  out_item_t (one per step)
//   cfg      input      APB psel/penable     five 16-bit registers
//
// A load is written to the RAM from the decode state; a step runs up to three
// divisions in turn on the shared one-bit-per-cycle divider.
// After reset a clearing pass zeroes every entry of the particle RAM;
// no transaction is accepted on the input meanwhile.
// A finished result waits in the output register without holding the input;
// the next result is held in its last state until that register empties.
// ----------------------------------------------------------------------------
module particle_project_bounce
  import ppb_pkg::*;
#(
  parameter int DOT_COUNT = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  logic    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_sine       <= 16'd0;
      cfg_q.rot_cosine     <= 16'd0;
      cfg_q.gravity_step   <= 16'd0;
      cfg_q.bounce_damping <= 16'd16;
      cfg_q.floor_level    <= 16'd8105;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_ROT_SINE:   cfg_q.rot_sine       <= pwdata[15:0];
        REG_ROT_COSINE: cfg_q.rot_cosine     <= pwdata[15:0];
        REG_GRAVITY:    cfg_q.gravity_step   <= pwdata[15:0];
        REG_DAMPING:    cfg_q.bounce_damping <= pwdata[15:0];
        REG_FLOOR:      cfg_q.floor_level    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ROT_SINE:   prdata = {16'd0, cfg_q.rot_sine};
      REG_ROT_COSINE: prdata = {16'd0, cfg_q.rot_cosine};
      REG_GRAVITY:    prdata = {16'd0, cfg_q.gravity_step};
      REG_DAMPING:    prdata = {16'd0, cfg_q.bounce_damping};
      REG_FLOOR:      prdata = {16'd0, cfg_q.floor_level};
      default:        prdata = 32'd0;
    endcase
  end

  ppb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ppb_dp #(
    .DOT_COUNT (DOT_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // one item in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on consecutive cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ball_drawn |-> out_data_o.shadow_drawn)
    else $error("ball drawn without shadow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.shadow_drawn |->
      out_data_o.screen_col <= 6'd39 && out_data_o.shadow_row <= 6'd47)
    else $error("drawn result off screen");

endmodule
`default_nettype wire

// ===== bench/ppb_checker.sv =====
// ----------------------------------------------------------------------------
// ppb_checker
// Watches the input and output transactions of particle_project_bounce,
// keeps its own particle table and registers, predicts each step result and
// compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module ppb_checker
  import ppb_pkg::*;
#(
  parameter int DOT_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count_o,
  output int          pending_o
);

  logic signed [15:0] sine, cosine, gravity, damping, floor_y;
  logic [15:0] xs [DOT_COUNT];
  logic [15:0] ys [DOT_COUNT];
  logic [15:0] zs [DOT_COUNT];
  logic [15:0] vs [DOT_COUNT];
  out_item_t   expected_frames [$];

  assign pending_o = expected_frames.size();

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  function automatic longint asr(input longint v, input int n);
    return v >>> n;
  endfunction

  function automatic out_item_t project_step(input int idx);
    out_item_t r;
    longint x, z, t, u, depth, col, shd, spd, ny, ball;
    r = '0;
    if (idx >= DOT_COUNT) return r;
    x = longint'($signed(xs[idx]));
    z = longint'($signed(zs[idx]));
    t = longint'($signed(32'(z * cosine - x * sine)));
    depth = (asr(t, 16) + 9000) & 65535;
    if (depth == 0) depth = 1;
    u = longint'($signed(32'(x * cosine + z * sine)));
    u = asr(u, 8);
    u = u + asr(u, 3);
    col = ((u / depth) / 8 + 20) & 65535;
    if (col > 39) return r;
    shd = (((524288 / depth / 4) & 65535) + 24) & 65535;
    if (shd > 47) return r;
    r.screen_col = col[5:0];
    r.shadow_row = shd[5:0];
    r.shadow_drawn = 1'b1;
    spd = longint'($signed(16'(longint'($signed(vs[idx])) + gravity)));
    ny = longint'($signed(16'(longint'($signed(ys[idx])) + spd)));
    if (ny >= floor_y) begin
      spd = asr(longint'($signed(16'(-spd * damping))), 4);
      ny = longint'($signed(16'(ny + spd)));
    end
    vs[idx] = 16'(spd);
    ys[idx] = 16'(ny);
    ball = (((ny * 64 / depth / 4) & 65535) + 24) & 65535;
    if (ball <= 47) begin
      r.ball_row = ball[5:0];
      r.ball_drawn = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      sine <= 0; cosine <= 0; gravity <= 0; damping <= 16; floor_y <= 8105;
      for (int i = 0; i < DOT_COUNT; i++) begin
        xs[i] = 0; ys[i] = 0; zs[i] = 0; vs[i] = 0;
      end
      expected_frames.delete();
      fail_count_o <= 0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[4:2])
          REG_ROT_SINE:   sine <= pwdata[15:0];
          REG_ROT_COSINE: cosine <= pwdata[15:0];
          REG_GRAVITY:    gravity <= pwdata[15:0];
          REG_DAMPING:    damping <= pwdata[15:0];
          REG_FLOOR:      floor_y <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.kind == KIND_LOAD) begin
          if (in_data_i.dot_index < DOT_COUNT) begin
            xs[in_data_i.dot_index] = in_data_i.pos_x;
            ys[in_data_i.dot_index] = in_data_i.pos_y;
            zs[in_data_i.dot_index] = in_data_i.pos_z;
            vs[in_data_i.dot_index] = in_data_i.speed_y;
          end
        end else begin
          expected_frames.push_back(project_step(in_data_i.dot_index));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          report("unexpected transaction", 1, 0);
        end else begin
          want = expected_frames.pop_front();
          if (out_data_i.screen_col != want.screen_col)
            report("screen_col", out_data_i.screen_col, want.screen_col);
          if (out_data_i.shadow_row != want.shadow_row)
            report("shadow_row", out_data_i.shadow_row, want.shadow_row);
          if (out_data_i.ball_row != want.ball_row)
            report("ball_row", out_data_i.ball_row, want.ball_row);
          if (out_data_i.shadow_drawn != want.shadow_drawn)
            report("shadow_drawn", out_data_i.shadow_drawn, want.shadow_drawn);
          if (out_data_i.ball_drawn != want.ball_drawn)
            report("ball_drawn", out_data_i.ball_drawn, want.ball_drawn);
        end
      end
    end
  end

endmodule

// ===== bench/particle_project_bounce_test.sv =====
// ----------------------------------------------------------------------------
// particle_project_bounce_test
// Drives loads and steps into particle_project_bounce under several register
// settings and random idling on both channels; the checker does the scoring.
// ----------------------------------------------------------------------------
module particle_project_bounce_test;
  import ppb_pkg::*;

  localparam int LIMIT = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, cycles;
  int          send_idle, recv_idle;

  particle_project_bounce DUT (.*);

  ppb_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel, .penable, .pwrite, .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= {16'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // ready is sampled at the falling edge, where it is settled
  task automatic send(input in_item_t it);
    while ($urandom_range(99) < send_idle) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load(input logic [7:0] i, input logic [15:0] x, y, z, v);
    in_item_t it;
    it = '{KIND_LOAD, i, x, y, z, v};
    send(it);
  endtask

  task automatic step(input logic [7:0] i);
    in_item_t it;
    it = '{~KIND_LOAD, i, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    send(it);
  endtask

  task automatic quiesce;
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // near-origin particles land on screen; the rest is full-range noise
  task automatic random_burst(input int n);
    logic [7:0] i;
    for (int k = 0; k < n; k++) begin
      i = 8'($urandom);
      case ($urandom_range(9))
        0, 1, 2: load(i, 16'($signed($urandom_range(800)) - 400),
                      16'($signed($urandom_range(16000)) - 8000),
                      16'($signed($urandom_range(800)) - 400),
                      16'($signed($urandom_range(400)) - 200));
        3: load(i, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        default: step(i);
      endcase
    end
  endtask

  initial begin
    send_idle = 36; recv_idle = 57;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: reset registers, extremes, step of never-loaded entry
    step(8'd0);
    step(8'd255);
    load(8'd0, 16'd0, 16'd8000, 16'd0, 16'd200);
    step(8'd0); step(8'd0);
    load(8'd255, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    step(8'd255);
    load(8'd1, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    step(8'd1);
    load(8'd2, 16'd100, 16'hffff, 16'hff00, 16'h0);
    step(8'd2);
    quiesce();
    write_reg(REG_ROT_SINE, 16'h7fff);
    write_reg(REG_ROT_COSINE, 16'h8000);
    write_reg(REG_GRAVITY, 16'h7fff);
    write_reg(REG_DAMPING, 16'h8000);
    write_reg(REG_FLOOR, 16'h8000);
    step(8'd0); step(8'd1); step(8'd2); step(8'd255);
    load(8'd3, 16'd1, 16'd1, 16'hdcd8, 16'd0);
    step(8'd3);
    random_burst(100);
    quiesce();
    write_reg(REG_ROT_SINE, 16'd0);
    write_reg(REG_ROT_COSINE, 16'h4000);
    write_reg(REG_GRAVITY, 16'd4);
    write_reg(REG_DAMPING, 16'd12);
    write_reg(REG_FLOOR, 16'd2000);
    send_idle = 57; recv_idle = 36;
    random_burst(150);
    quiesce();
    write_reg(REG_ROT_SINE, 16'h2d41);
    write_reg(REG_ROT_COSINE, 16'h2d41);
    write_reg(REG_GRAVITY, 16'hfff0);
    write_reg(REG_DAMPING, 16'h7fff);
    write_reg(REG_FLOOR, 16'h7fff);
    send_idle = 0; recv_idle = 0;
    random_burst(80);
    quiesce();
    write_reg(REG_ROT_SINE, 16'($urandom));
    write_reg(REG_ROT_COSINE, 16'($urandom));
    write_reg(REG_GRAVITY, 16'($urandom));
    write_reg(REG_DAMPING, 16'($urandom));
    write_reg(REG_FLOOR, 16'($urandom));
    random_burst(100);
    quiesce();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
